FILE: hw/rtl/lzpbp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lzpbp_pkg
// Shared constants and types for the predictor byte codec.
// ----------------------------------------------------------------------------
package lzpbp_pkg;

  localparam int LZPBP_TABLE_BITS = 16;
  localparam int LZPBP_MIN_BITS   = 8;
  localparam int LZPBP_SHIFT      = 5;

  localparam int CFG_DATA_W = 5;

  localparam logic [CFG_DATA_W-1:0] TABLE_BITS_RESET = 5'd16;

  typedef enum logic [0:0] {
    REG_MODE       = 1'b0,
    REG_TABLE_BITS = 1'b1
  } cfg_idx_t;

  typedef enum logic {
    MODE_COMPRESS   = 1'b0,
    MODE_DECOMPRESS = 1'b1
  } mode_t;

  typedef struct packed {
    mode_t                 mode;
    logic [CFG_DATA_W-1:0] bits;
  } cfg_t;

endpackage
`default_nettype wire

FILE: hw/rtl/lzpbp_guess_mem.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lzpbp_guess_mem
// Guess table: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module lzpbp_guess_mem #(
  parameter int ADDR_W = 16
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [7:0]        wdata,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [7:0]        rdata
);

  logic [7:0] mem [0:(1 << ADDR_W)-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/lzpbp_cfg_regs.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lzpbp_cfg_regs
// Mode and table-bits registers; table bits saturated for use.
// ----------------------------------------------------------------------------
module lzpbp_cfg_regs
  import lzpbp_pkg::*;
#(
  parameter int TABLE_BITS = LZPBP_TABLE_BITS
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [0:0]            cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                       cfg
);

  mode_t                 mode;
  logic [CFG_DATA_W-1:0] table_bits;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= MODE_COMPRESS;
      table_bits <= TABLE_BITS_RESET;
    end else if (cfg_valid) begin
      case (cfg_idx_t'(cfg_index))
        REG_MODE:       mode <= mode_t'(cfg_data[0]);
        REG_TABLE_BITS: table_bits <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.mode = mode;
    if (table_bits < CFG_DATA_W'(LZPBP_MIN_BITS)) begin
      cfg.bits = CFG_DATA_W'(LZPBP_MIN_BITS);
    end else if (table_bits > CFG_DATA_W'(TABLE_BITS)) begin
      cfg.bits = CFG_DATA_W'(TABLE_BITS);
    end else begin
      cfg.bits = table_bits;
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/lzpbp_stage.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lzpbp_stage
// Resolve stage: guess with write forwarding, hit/literal decision,
// table update and next context hash.
// ----------------------------------------------------------------------------
module lzpbp_stage
  import lzpbp_pkg::*;
#(
  parameter int TABLE_BITS = LZPBP_TABLE_BITS
) (
  input  wire logic [TABLE_BITS-1:0] mask,
  input  wire mode_t                 mode,
  input  wire logic [TABLE_BITS-1:0] idx,
  input  wire logic [7:0]            data,
  input  wire logic                  hit_in,
  input  wire logic [7:0]            rdata,
  input  wire logic                  fwd_hit,
  input  wire logic [7:0]            fwd_data,
  output logic                       hit,
  output logic [7:0]                 shown,
  output logic                       valid,
  output logic                       we,
  output logic [TABLE_BITS-1:0]      hash_new
);

  logic [7:0]            guess;
  logic [7:0]            byte_sel;
  logic [TABLE_BITS-1:0] shifted;

  assign guess = fwd_hit ? fwd_data : rdata;

  always_comb begin
    case (mode)
      MODE_COMPRESS: begin
        hit      = (guess == data);
        byte_sel = data;
        valid    = ~hit;
        shown    = hit ? 8'd0 : data;
      end
      MODE_DECOMPRESS: begin
        hit      = hit_in;
        byte_sel = hit_in ? guess : data;
        valid    = 1'b1;
        shown    = byte_sel;
      end
      default: begin
        hit      = 1'b0;
        byte_sel = data;
        valid    = 1'b1;
        shown    = data;
      end
    endcase
  end

  assign we       = ~hit;
  assign shifted  = idx << LZPBP_SHIFT;
  assign hash_new = (shifted + {{(TABLE_BITS-8){1'b0}}, byte_sel}) & mask;

endmodule
`default_nettype wire

FILE: hw/rtl/lzp_byte_predictor_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lzp_byte_predictor_unit
// Predictor byte codec: context hash indexes a byte guess table.
// ----------------------------------------------------------------------------
// Input channel: in_valid/in_stall with data_byte and hit_in. Output channel:
// out_valid/out_stall with hit_out, out_byte and byte_valid, exactly one word
// out per word in. Config channel: cfg_valid/cfg_ready with cfg_index and
// cfg_data; index 0 is mode, 1 is table_bits. Write it only when idle.
// Pipeline: accept cycle issues the table read, the next cycle resolves the
// guess and, when the output register can take the word, writes the table and
// hands it over. Throughput is one word per cycle while the receiver does not
// stall; the next hash is forwarded from the resolve stage straight to the read
// address, and a same-entry write is forwarded into the following read.
// After reset the guess table is swept to zero, one entry per cycle, across all
// 2**TABLE_BITS entries (65536 by default); in_stall is high meanwhile.
// When the receiver stalls, the output register holds, the resolve stage
// holds behind it and in_stall rises.
// ----------------------------------------------------------------------------
module lzp_byte_predictor_unit
  import lzpbp_pkg::*;
#(
  parameter int TABLE_BITS = LZPBP_TABLE_BITS
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [7:0]            data_byte,
  input  wire logic                  hit_in,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic                       hit_out,
  output logic [7:0]                 out_byte,
  output logic                       byte_valid,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [0:0]            cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t                  cfg;
  logic [TABLE_BITS-1:0] mask;

  logic                  clearing;
  logic [TABLE_BITS-1:0] clr_addr;

  logic [TABLE_BITS-1:0] hash;
  logic [TABLE_BITS-1:0] rd_addr;
  logic                  in_fire;

  logic                  s2_valid;
  logic [TABLE_BITS-1:0] s2_idx;
  logic [7:0]            s2_data;
  logic                  s2_hit_in;
  logic                  fwd_hit;
  logic [7:0]            fwd_data;
  logic                  s2_fire;

  logic                  r_hit;
  logic [7:0]            r_shown;
  logic                  r_valid;
  logic                  r_we;
  logic [TABLE_BITS-1:0] hash_new;

  logic [7:0]            rdata;
  logic                  mem_we;
  logic [TABLE_BITS-1:0] mem_waddr;
  logic [7:0]            mem_wdata;
  logic                  wr_fire;

  lzpbp_cfg_regs #(.TABLE_BITS(TABLE_BITS)) u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  assign mask = ~({TABLE_BITS{1'b1}} << cfg.bits);

  lzpbp_stage #(.TABLE_BITS(TABLE_BITS)) u_stage (
    .mask     (mask),
    .mode     (cfg.mode),
    .idx      (s2_idx),
    .data     (s2_data),
    .hit_in   (s2_hit_in),
    .rdata    (rdata),
    .fwd_hit  (fwd_hit),
    .fwd_data (fwd_data),
    .hit      (r_hit),
    .shown    (r_shown),
    .valid    (r_valid),
    .we       (r_we),
    .hash_new (hash_new)
  );

  assign s2_fire  = s2_valid && (!out_valid || !out_stall);
  assign in_stall = clearing || (s2_valid && !s2_fire);
  assign in_fire  = in_valid && !in_stall;
  assign rd_addr  = (s2_valid ? hash_new : hash) & mask;
  assign wr_fire  = s2_fire && r_we;

  always_comb begin
    if (clearing) begin
      mem_we    = 1'b1;
      mem_waddr = clr_addr;
      mem_wdata = 8'd0;
    end else begin
      mem_we    = wr_fire;
      mem_waddr = s2_idx;
      mem_wdata = s2_data;
    end
  end

  lzpbp_guess_mem #(.ADDR_W(TABLE_BITS)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (in_fire),
    .raddr (rd_addr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == {TABLE_BITS{1'b1}}) begin
        clearing <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hash <= '0;
    end else if (s2_fire) begin
      hash <= hash_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (in_fire) begin
      s2_valid <= 1'b1;
    end else if (s2_fire) begin
      s2_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s2_idx    <= rd_addr;
      s2_data   <= data_byte;
      s2_hit_in <= hit_in;
      fwd_hit   <= wr_fire && (s2_idx == rd_addr);
      fwd_data  <= s2_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s2_fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_fire) begin
      hit_out    <= r_hit;
      out_byte   <= r_shown;
      byte_valid <= r_valid;
    end
  end

  a_s2_holds: assert property (@(posedge clk) disable iff (rst)
    s2_valid && !s2_fire |=> s2_valid && $stable(s2_idx) && $stable(s2_data))
    else $error("resolve stage lost its word while stalled");

  a_no_work_while_clearing: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !s2_valid && !out_valid)
    else $error("word in flight during table clear");

  a_hash_update: assert property (@(posedge clk) disable iff (rst)
    s2_fire |=> hash == $past(hash_new))
    else $error("context hash not updated from resolved word");

  a_fwd_source: assert property (@(posedge clk) disable iff (rst)
    in_fire && wr_fire && (s2_idx == rd_addr) |=> fwd_hit && s2_valid)
    else $error("same-entry write not forwarded");

endmodule
`default_nettype wire
